>>> design/tvbb_pkg.sv
`default_nettype none

package tvbb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * COORD_W;
    // three products, the translation term and the rounding half fit in 66 bits
    localparam int ACC_W     = PROD_W + 2;
    localparam int SAT_W     = ACC_W - FRAC_BITS - COORD_W + 1;
    localparam int AXES      = 3;

    localparam logic [CFG_W-1:0] ONE_FX  = CFG_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF_FX = ACC_W'(1) << (FRAC_BITS - 1);

    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_TEST   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic adv_b;    // stage A word moves into the product stage
        logic adv_c;    // product stage word moves into the sum stage
    } t_pipe_ctl;

    // identity matrix, zero translation
    function automatic logic [CFG_W-1:0] cfg_reset_value(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        v = '0;
        case (idx)
            REG_ROW0_C01: v = ONE_FX;
            REG_ROW1_C01: v = ONE_FX << COORD_W;
            REG_ROW2_C23: v = ONE_FX;
            default:      v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/tvbb_row.sv
`default_nettype none

module tvbb_row (
    input  wire                          i_clk,
    input  tvbb_pkg::t_pipe_ctl          i_ctl,
    input  wire [tvbb_pkg::CFG_W-1:0]    i_coef01,
    input  wire [tvbb_pkg::CFG_W-1:0]    i_coef23,
    input  tvbb_pkg::t_coord             i_x,
    input  tvbb_pkg::t_coord             i_y,
    input  tvbb_pkg::t_coord             i_z,
    output tvbb_pkg::t_coord             o_p
);

    logic signed [tvbb_pkg::PROD_W-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic signed [tvbb_pkg::PROD_W-1:0] n_prod_x, n_prod_y, n_prod_z;
    logic signed [tvbb_pkg::ACC_W-1:0]  r_ofs, n_ofs;
    logic signed [tvbb_pkg::ACC_W-1:0]  acc;
    logic [tvbb_pkg::SAT_W-1:0]         acc_top;
    tvbb_pkg::t_coord                   m0, m1, m2, tr;
    tvbb_pkg::t_coord                   r_p, n_p;

    assign m0 = tvbb_pkg::t_coord'(i_coef01[tvbb_pkg::COORD_W-1:0]);
    assign m1 = tvbb_pkg::t_coord'(i_coef01[tvbb_pkg::CFG_W-1:tvbb_pkg::COORD_W]);
    assign m2 = tvbb_pkg::t_coord'(i_coef23[tvbb_pkg::COORD_W-1:0]);
    assign tr = tvbb_pkg::t_coord'(i_coef23[tvbb_pkg::CFG_W-1:tvbb_pkg::COORD_W]);

    always_comb begin
        n_prod_x = m0 * i_x;
        n_prod_y = m1 * i_y;
        n_prod_z = m2 * i_z;
        n_ofs    = (tvbb_pkg::ACC_W'(tr) <<< tvbb_pkg::FRAC_BITS)
                 + $signed(tvbb_pkg::HALF_FX);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_b) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
            r_ofs    <= n_ofs;
        end
    end

    // round by the added half, shift out the fraction, saturate to 32 bits
    always_comb begin
        acc = tvbb_pkg::ACC_W'(r_prod_x) + tvbb_pkg::ACC_W'(r_prod_y)
            + tvbb_pkg::ACC_W'(r_prod_z) + r_ofs;
        acc_top = acc[tvbb_pkg::ACC_W-1:tvbb_pkg::FRAC_BITS+tvbb_pkg::COORD_W-1];
        if (acc_top == '0 || acc_top == '1) begin
            n_p = acc[tvbb_pkg::FRAC_BITS+tvbb_pkg::COORD_W-1:tvbb_pkg::FRAC_BITS];
        end else if (acc[tvbb_pkg::ACC_W-1]) begin
            n_p = {1'b1, {(tvbb_pkg::COORD_W-1){1'b0}}};
        end else begin
            n_p = {1'b0, {(tvbb_pkg::COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_c) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> design/tvbb_box.sv
`default_nettype none

module tvbb_box (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire                 i_func,
    input  wire                 i_first,
    input  tvbb_pkg::t_coord    i_p_x,
    input  tvbb_pkg::t_coord    i_p_y,
    input  tvbb_pkg::t_coord    i_p_z,
    input  tvbb_pkg::t_coord    i_x,
    input  tvbb_pkg::t_coord    i_y,
    input  tvbb_pkg::t_coord    i_z,
    output logic                o_box_valid,
    output logic                o_inside_res,
    output tvbb_pkg::t_coord    o_max_x,
    output tvbb_pkg::t_coord    o_max_y,
    output tvbb_pkg::t_coord    o_max_z,
    output tvbb_pkg::t_coord    o_min_x,
    output tvbb_pkg::t_coord    o_min_y,
    output tvbb_pkg::t_coord    o_min_z
);

    tvbb_pkg::t_coord r_max [tvbb_pkg::AXES];
    tvbb_pkg::t_coord r_min [tvbb_pkg::AXES];
    tvbb_pkg::t_coord n_max [tvbb_pkg::AXES];
    tvbb_pkg::t_coord n_min [tvbb_pkg::AXES];
    tvbb_pkg::t_coord pt    [tvbb_pkg::AXES];
    tvbb_pkg::t_coord wp    [tvbb_pkg::AXES];
    logic             r_has_box, n_has_box;
    logic             r_inside, n_inside;
    logic             in_box;

    assign pt[0] = i_p_x;
    assign pt[1] = i_p_y;
    assign pt[2] = i_p_z;
    assign wp[0] = i_x;
    assign wp[1] = i_y;
    assign wp[2] = i_z;

    always_comb begin
        n_has_box = r_has_box;
        n_inside  = 1'b0;
        in_box    = r_has_box;
        for (int a = 0; a < tvbb_pkg::AXES; a++) begin
            n_max[a] = r_max[a];
            n_min[a] = r_min[a];
            if (wp[a] > r_max[a] || wp[a] < r_min[a]) begin
                in_box = 1'b0;
            end
        end
        if (i_func == tvbb_pkg::FUNC_VERTEX) begin
            n_has_box = 1'b1;
            for (int a = 0; a < tvbb_pkg::AXES; a++) begin
                // restart on first word or empty box, else widen
                if (i_first || !r_has_box || pt[a] > r_max[a]) begin
                    n_max[a] = pt[a];
                end
                if (i_first || !r_has_box || pt[a] < r_min[a]) begin
                    n_min[a] = pt[a];
                end
            end
        end else begin
            n_inside = in_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_box <= 1'b0;
            r_inside  <= 1'b0;
            for (int a = 0; a < tvbb_pkg::AXES; a++) begin
                r_max[a] <= '0;
                r_min[a] <= '0;
            end
        end else if (i_load) begin
            r_has_box <= n_has_box;
            r_inside  <= n_inside;
            for (int a = 0; a < tvbb_pkg::AXES; a++) begin
                r_max[a] <= n_max[a];
                r_min[a] <= n_min[a];
            end
        end
    end

    assign o_box_valid  = r_has_box;
    assign o_inside_res = r_inside;
    assign o_max_x      = r_max[0];
    assign o_max_y      = r_max[1];
    assign o_max_z      = r_max[2];
    assign o_min_x      = r_min[0];
    assign o_min_y      = r_min[1];
    assign o_min_z      = r_min[2];

endmodule

`default_nettype wire

>>> design/transformed_vertex_bounding_box.sv
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_func, i_first, i_coord_x/y/z
// result    out        o_valid / i_stall  o_box_valid, o_inside_res, o_max_*, o_min_*
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data (64 bits)
//
// One word per cycle sustained while i_stall is low; four pipeline registers
// (input, products, rounded sum, box) carry each word to the result register.
// The box state itself is the result register and is updated in word order.
// Synchronous active-low reset clears the box, all valid flags and loads the
// identity matrix. Empty stages fill while the output is stalled; o_stall rises
// only when all four stages hold a word and i_stall is high.
`default_nettype none

module transformed_vertex_bounding_box (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire                               i_func,
    input  wire                               i_first,
    input  tvbb_pkg::t_coord                  i_coord_x,
    input  tvbb_pkg::t_coord                  i_coord_y,
    input  tvbb_pkg::t_coord                  i_coord_z,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_box_valid,
    output logic                              o_inside_res,
    output tvbb_pkg::t_coord                  o_max_x,
    output tvbb_pkg::t_coord                  o_max_y,
    output tvbb_pkg::t_coord                  o_max_z,
    output tvbb_pkg::t_coord                  o_min_x,
    output tvbb_pkg::t_coord                  o_min_y,
    output tvbb_pkg::t_coord                  o_min_z,
    input  wire                               i_cfg_we,
    input  wire [tvbb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [tvbb_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [tvbb_pkg::CFG_W-1:0] r_cfg [tvbb_pkg::NUM_REGS];

    logic             r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic             r_a_func, r_b_func, r_c_func;
    logic             r_a_first, r_b_first, r_c_first;
    tvbb_pkg::t_coord r_a_x, r_a_y, r_a_z;
    tvbb_pkg::t_coord r_b_x, r_b_y, r_b_z;
    tvbb_pkg::t_coord r_c_x, r_c_y, r_c_z;
    tvbb_pkg::t_coord p_x, p_y, p_z;

    logic                rdy_a, rdy_b, rdy_c, rdy_d;
    logic                adv_a, adv_d;
    tvbb_pkg::t_pipe_ctl ctl;

    // a stage takes a new word when empty or when its word moves on
    always_comb begin
        rdy_d     = !r_d_valid || !i_stall;
        rdy_c     = !r_c_valid || rdy_d;
        rdy_b     = !r_b_valid || rdy_c;
        rdy_a     = !r_a_valid || rdy_b;
        adv_a     = i_valid && rdy_a;
        ctl.adv_b = r_a_valid && rdy_b;
        ctl.adv_c = r_b_valid && rdy_c;
        adv_d     = r_c_valid && rdy_d;
    end

    assign o_stall = !rdy_a;
    assign o_valid = r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tvbb_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= tvbb_pkg::cfg_reset_value(tvbb_pkg::CFG_IDX_W'(i));
            end
        end else if (i_cfg_we && i_cfg_idx < tvbb_pkg::CFG_IDX_W'(tvbb_pkg::NUM_REGS)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_func  <= i_func;
            r_a_first <= i_first;
            r_a_x     <= i_coord_x;
            r_a_y     <= i_coord_y;
            r_a_z     <= i_coord_z;
        end
        if (ctl.adv_b) begin
            r_b_func  <= r_a_func;
            r_b_first <= r_a_first;
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
            r_b_z     <= r_a_z;
        end
        if (ctl.adv_c) begin
            r_c_func  <= r_b_func;
            r_c_first <= r_b_first;
            r_c_x     <= r_b_x;
            r_c_y     <= r_b_y;
            r_c_z     <= r_b_z;
        end
    end

    tvbb_row u_row_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coef01 (r_cfg[tvbb_pkg::REG_ROW0_C01]),
        .i_coef23 (r_cfg[tvbb_pkg::REG_ROW0_C23]),
        .i_x      (r_a_x),
        .i_y      (r_a_y),
        .i_z      (r_a_z),
        .o_p      (p_x)
    );

    tvbb_row u_row_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coef01 (r_cfg[tvbb_pkg::REG_ROW1_C01]),
        .i_coef23 (r_cfg[tvbb_pkg::REG_ROW1_C23]),
        .i_x      (r_a_x),
        .i_y      (r_a_y),
        .i_z      (r_a_z),
        .o_p      (p_y)
    );

    tvbb_row u_row_z (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_coef01 (r_cfg[tvbb_pkg::REG_ROW2_C01]),
        .i_coef23 (r_cfg[tvbb_pkg::REG_ROW2_C23]),
        .i_x      (r_a_x),
        .i_y      (r_a_y),
        .i_z      (r_a_z),
        .o_p      (p_z)
    );

    tvbb_box u_box (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (adv_d),
        .i_func       (r_c_func),
        .i_first      (r_c_first),
        .i_p_x        (p_x),
        .i_p_y        (p_y),
        .i_p_z        (p_z),
        .i_x          (r_c_x),
        .i_y          (r_c_y),
        .i_z          (r_c_z),
        .o_box_valid  (o_box_valid),
        .o_inside_res (o_inside_res),
        .o_max_x      (o_max_x),
        .o_max_y      (o_max_y),
        .o_max_z      (o_max_z),
        .o_min_x      (o_min_x),
        .o_min_y      (o_min_y),
        .o_min_z      (o_min_z)
    );

    a_inside_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_res |-> o_box_valid)
        else $error("point test inside without a box");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box_valid |-> o_min_x <= o_max_x && o_min_y <= o_max_y && o_min_z <= o_max_z)
        else $error("box lower bound above upper bound");

    a_box_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box_valid |=> o_box_valid)
        else $error("box valid dropped without reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_valid && r_b_valid && r_c_valid && r_d_valid && i_stall)
        else $error("input stalled with a free pipeline stage");

    a_box_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_c_valid |=> $stable(o_max_x) && $stable(o_min_x) && $stable(o_box_valid))
        else $error("box changed with no word in the sum stage");

endmodule

`default_nettype wire
